// File: rtl/core/itpt_pkg.sv
// indexed task priority table: shared types, widths and codes
// used by the top level, the port checker and the testbench; no dependencies

package itpt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int KIND_W   = 2;
    localparam int USER_W   = 20;
    localparam int TASK_W   = 20;
    localparam int PRIO_W   = 30;
    localparam int STATUS_W = 3;

    localparam int SLOT_W = USER_W + TASK_W + PRIO_W;
    localparam int KEY_W  = PRIO_W + TASK_W;

    localparam int IN_FIELDS_W  = USER_W + TASK_W + PRIO_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + USER_W + TASK_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_EDIT   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_POP    = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_FULL      = 3'd2,
        STS_DUPLICATE = 3'd3,
        STS_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } t_state;

endpackage

// File: rtl/core/itpt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module itpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/indexed_task_priority_table_top.sv
// indexed task priority table: top level with request sequencer and scan unit
// depends on itpt_pkg and itpt_ram
//
// usage
// a request item enters on the s_axis channel: tuser carries the kind (add, edit,
// remove, pop), tdata carries user id, task id and priority. each request gives
// exactly one result item on the m_axis channel: status, owner and task id.
// s_axis_tready is high only while the sequencer is idle; one request is taken
// at a time. a request reads every slot of the table ram once, one slot per
// cycle, through one shared compare unit that tracks the id match, the first
// free slot and the best (priority, task id) key. the ram read is registered,
// so each slot is compared once its read data is registered; an update step
// and an output step follow the scan. the next request is taken once the
// block is back in the idle step, after the result is loaded.
// the output register holds the result while m_axis_tready is low; the block
// waits in the output step and takes no new request until the result is loaded.
// a synchronous active-low reset clears all slot valid bits and empties the
// output register; slot contents are not cleared, no clearing pass is needed.

module indexed_task_priority_table_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // user_id [19:0], task_id [39:20], priority_req [69:40], zero fill
    input  logic [itpt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind [1:0]
    input  logic [itpt_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status [2:0], owner_out [22:3], task_out [42:23], zero fill
    output logic [itpt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int IDX_W = itpt_pkg::IDX_W;
    localparam int CNT_W = itpt_pkg::CNT_W;

    itpt_pkg::t_state r_state, n_state;

    logic [itpt_pkg::ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic                         r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]             r_rd_idx, n_rd_idx;

    itpt_pkg::t_kind              r_kind, n_kind;
    logic [itpt_pkg::USER_W-1:0]  r_req_user, n_req_user;
    logic [itpt_pkg::TASK_W-1:0]  r_req_task, n_req_task;
    logic [itpt_pkg::PRIO_W-1:0]  r_req_prio, n_req_prio;

    logic                         r_hit, n_hit;
    logic [IDX_W-1:0]             r_hit_idx, n_hit_idx;
    logic [itpt_pkg::USER_W-1:0]  r_hit_owner, n_hit_owner;
    logic                         r_free, n_free;
    logic [IDX_W-1:0]             r_free_idx, n_free_idx;
    logic                         r_best, n_best;
    logic [IDX_W-1:0]             r_best_idx, n_best_idx;
    logic [itpt_pkg::KEY_W-1:0]   r_best_key, n_best_key;
    logic [itpt_pkg::USER_W-1:0]  r_best_owner, n_best_owner;

    itpt_pkg::t_status            r_res_status, n_res_status;
    logic [itpt_pkg::USER_W-1:0]  r_res_owner, n_res_owner;
    logic [itpt_pkg::TASK_W-1:0]  r_res_task, n_res_task;

    logic                           r_m_tvalid, n_m_tvalid;
    logic [itpt_pkg::OUT_DATA_W-1:0] r_m_tdata, n_m_tdata;

    logic                          ram_wr_en;
    logic [IDX_W-1:0]              ram_wr_addr;
    logic [itpt_pkg::SLOT_W-1:0]   ram_wr_data;
    logic                          ram_rd_en;
    logic [IDX_W-1:0]              ram_rd_addr;
    logic [itpt_pkg::SLOT_W-1:0]   ram_rd_data;

    logic                          rd_slot_valid;
    logic [itpt_pkg::PRIO_W-1:0]   rd_prio;
    logic [itpt_pkg::TASK_W-1:0]   rd_task;
    logic [itpt_pkg::USER_W-1:0]   rd_owner;
    logic [itpt_pkg::KEY_W-1:0]    rd_key;

    // slot word: owner, task, priority from the top bit down
    assign rd_prio       = ram_rd_data[itpt_pkg::PRIO_W-1:0];
    assign rd_task       = ram_rd_data[itpt_pkg::PRIO_W +: itpt_pkg::TASK_W];
    assign rd_owner      = ram_rd_data[itpt_pkg::KEY_W +: itpt_pkg::USER_W];
    assign rd_key        = {rd_prio, rd_task};
    assign rd_slot_valid = r_valid[r_rd_idx];

    itpt_ram #(
        .WIDTH (itpt_pkg::SLOT_W),
        .DEPTH (itpt_pkg::ENTRIES)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= itpt_pkg::ST_IDLE;
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_rd_vld   <= n_rd_vld;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_rd_idx     <= n_rd_idx;
        r_kind       <= n_kind;
        r_req_user   <= n_req_user;
        r_req_task   <= n_req_task;
        r_req_prio   <= n_req_prio;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_hit_owner  <= n_hit_owner;
        r_free       <= n_free;
        r_free_idx   <= n_free_idx;
        r_best       <= n_best;
        r_best_idx   <= n_best_idx;
        r_best_key   <= n_best_key;
        r_best_owner <= n_best_owner;
        r_res_status <= n_res_status;
        r_res_owner  <= n_res_owner;
        r_res_task   <= n_res_task;
        r_m_tdata    <= n_m_tdata;
    end

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_cnt        = r_cnt;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_idx;
        n_kind       = r_kind;
        n_req_user   = r_req_user;
        n_req_task   = r_req_task;
        n_req_prio   = r_req_prio;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_owner  = r_hit_owner;
        n_free       = r_free;
        n_free_idx   = r_free_idx;
        n_best       = r_best;
        n_best_idx   = r_best_idx;
        n_best_key   = r_best_key;
        n_best_owner = r_best_owner;
        n_res_status = r_res_status;
        n_res_owner  = r_res_owner;
        n_res_task   = r_res_task;
        n_m_tvalid   = r_m_tvalid && !m_axis_tready;
        n_m_tdata    = r_m_tdata;

        s_axis_tready = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = r_free_idx;
        ram_wr_data   = {r_req_user, r_req_task, r_req_prio};
        ram_rd_en     = 1'b0;
        ram_rd_addr   = r_cnt[IDX_W-1:0];

        unique case (r_state)
            itpt_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_kind     = itpt_pkg::t_kind'(s_axis_tuser);
                    n_req_user = s_axis_tdata[itpt_pkg::USER_W-1:0];
                    n_req_task = s_axis_tdata[itpt_pkg::USER_W +: itpt_pkg::TASK_W];
                    n_req_prio = s_axis_tdata[(itpt_pkg::USER_W + itpt_pkg::TASK_W) +:
                                              itpt_pkg::PRIO_W];
                    n_cnt      = '0;
                    n_hit      = 1'b0;
                    n_free     = 1'b0;
                    n_best     = 1'b0;
                    n_state    = itpt_pkg::ST_SCAN;
                end
            end

            itpt_pkg::ST_SCAN: begin
                if (r_cnt != CNT_W'(itpt_pkg::ENTRIES)) begin
                    ram_rd_en = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_cnt[IDX_W-1:0];
                    n_cnt     = r_cnt + CNT_W'(1);
                end else if (!r_rd_vld) begin
                    n_state = itpt_pkg::ST_UPDATE;
                end
                if (r_rd_vld) begin
                    if (rd_slot_valid && rd_task == r_req_task && !r_hit) begin
                        n_hit       = 1'b1;
                        n_hit_idx   = r_rd_idx;
                        n_hit_owner = rd_owner;
                    end
                    if (!rd_slot_valid && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_rd_idx;
                    end
                    if (rd_slot_valid && (!r_best || rd_key > r_best_key)) begin
                        n_best       = 1'b1;
                        n_best_idx   = r_rd_idx;
                        n_best_key   = rd_key;
                        n_best_owner = rd_owner;
                    end
                end
            end

            itpt_pkg::ST_UPDATE: begin
                n_res_status = itpt_pkg::STS_OK;
                n_res_owner  = '0;
                n_res_task   = '0;
                case (r_kind)
                    itpt_pkg::KIND_ADD: begin
                        if (r_hit) begin
                            n_res_status = itpt_pkg::STS_DUPLICATE;
                        end else if (!r_free) begin
                            n_res_status = itpt_pkg::STS_FULL;
                        end else begin
                            ram_wr_en           = 1'b1;
                            n_valid[r_free_idx] = 1'b1;
                        end
                    end
                    itpt_pkg::KIND_EDIT: begin
                        if (!r_hit) begin
                            n_res_status = itpt_pkg::STS_NOT_FOUND;
                        end else begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = r_hit_idx;
                            ram_wr_data = {r_hit_owner, r_req_task, r_req_prio};
                        end
                    end
                    itpt_pkg::KIND_REMOVE: begin
                        if (!r_hit) begin
                            n_res_status = itpt_pkg::STS_NOT_FOUND;
                        end else begin
                            n_valid[r_hit_idx] = 1'b0;
                        end
                    end
                    default: begin
                        if (!r_best) begin
                            n_res_status = itpt_pkg::STS_EMPTY;
                        end else begin
                            n_valid[r_best_idx] = 1'b0;
                            n_res_owner = r_best_owner;
                            n_res_task  = r_best_key[itpt_pkg::TASK_W-1:0];
                        end
                    end
                endcase
                n_state = itpt_pkg::ST_RESP;
            end

            itpt_pkg::ST_RESP: begin
                if (!r_m_tvalid || m_axis_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = itpt_pkg::OUT_DATA_W'({r_res_task, r_res_owner, r_res_status});
                    n_state    = itpt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = itpt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule

// File: rtl/core/itpt_checker.sv
// port checker for the indexed task priority table, bound to the top level
// depends on itpt_pkg and indexed_task_priority_table_top

module itpt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [itpt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic [itpt_pkg::STATUS_W-1:0] status;
    logic [itpt_pkg::USER_W-1:0]   owner;
    logic [itpt_pkg::TASK_W-1:0]   task_id;

    assign status  = m_axis_tdata[itpt_pkg::STATUS_W-1:0];
    assign owner   = m_axis_tdata[itpt_pkg::STATUS_W +: itpt_pkg::USER_W];
    assign task_id = m_axis_tdata[(itpt_pkg::STATUS_W + itpt_pkg::USER_W) +: itpt_pkg::TASK_W];

    // a stalled result item stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item valid after reset");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // failed requests carry no owner or task
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != itpt_pkg::STS_OK |-> owner == '0 && task_id == '0)
        else $error("nonzero payload on failed request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> status <= itpt_pkg::STS_EMPTY)
        else $error("undefined status code");

endmodule

bind indexed_task_priority_table_top itpt_checker u_itpt_checker (.*);

// File: dv/tb_indexed_task_priority_table_top.sv
// testbench for indexed_task_priority_table_top: drives add, edit, remove and pop requests
// and checks every result against a table model held in a small scoreboard class
// depends on itpt_pkg and the rtl of the top level

module tb_indexed_task_priority_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itpt_pkg::*;

    localparam int N_RANDOM  = 1600;
    localparam int DRAIN_CYC = ENTRIES + 16;

    typedef struct {
        t_status           status;
        logic [USER_W-1:0] owner;
        logic [TASK_W-1:0] tid;
    } reply_t;

    class task_table_model;
        bit                slot_used[ENTRIES];
        logic [TASK_W-1:0] slot_id[ENTRIES];
        logic [USER_W-1:0] slot_owner[ENTRIES];
        logic [PRIO_W-1:0] slot_prio[ENTRIES];
        reply_t            expected_replies[$];
        int                errors;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int find_slot(logic [TASK_W-1:0] id);
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i] && slot_id[i] == id) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (slot_used[i]) begin
                if (slot_used[i]) begin
                    n++;
                end
            end
            return n;
        endfunction

        function logic [TASK_W-1:0] random_live_id();
            int pick;
            pick = $urandom_range(0, live_count() - 1);
            foreach (slot_used[i]) begin
                if (slot_used[i]) begin
                    if (pick == 0) begin
                        return slot_id[i];
                    end
                    pick--;
                end
            end
            return '0;
        endfunction

        // predict the reply of one accepted request and update the table
        function void apply_request(t_kind kind, logic [USER_W-1:0] user,
                                    logic [TASK_W-1:0] id, logic [PRIO_W-1:0] prio);
            reply_t r;
            int     hit;
            r.status = STS_OK;
            r.owner  = '0;
            r.tid    = '0;
            hit      = -1;
            case (kind)
                KIND_ADD: begin
                    if (find_slot(id) >= 0) begin
                        r.status = STS_DUPLICATE;
                    end else begin
                        for (int i = 0; i < ENTRIES && hit < 0; i++) begin
                            if (!slot_used[i]) begin
                                hit = i;
                            end
                        end
                        if (hit < 0) begin
                            r.status = STS_FULL;
                        end else begin
                            slot_used[hit]  = 1'b1;
                            slot_id[hit]    = id;
                            slot_owner[hit] = user;
                            slot_prio[hit]  = prio;
                        end
                    end
                end
                KIND_EDIT: begin
                    hit = find_slot(id);
                    if (hit < 0) begin
                        r.status = STS_NOT_FOUND;
                    end else begin
                        slot_prio[hit] = prio;
                    end
                end
                KIND_REMOVE: begin
                    hit = find_slot(id);
                    if (hit < 0) begin
                        r.status = STS_NOT_FOUND;
                    end else begin
                        slot_used[hit] = 1'b0;
                    end
                end
                default: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_used[i] && (hit < 0 || slot_prio[i] > slot_prio[hit] ||
                            (slot_prio[i] == slot_prio[hit] && slot_id[i] > slot_id[hit]))) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        r.status = STS_EMPTY;
                    end else begin
                        r.owner        = slot_owner[hit];
                        r.tid          = slot_id[hit];
                        slot_used[hit] = 1'b0;
                    end
                end
            endcase
            expected_replies.push_back(r);
        endfunction

        function void compare_reply(logic [OUT_DATA_W-1:0] data);
            reply_t            want;
            logic [STATUS_W-1:0] got_status;
            logic [USER_W-1:0] got_owner;
            logic [TASK_W-1:0] got_tid;
            got_status = data[STATUS_W-1:0];
            got_owner  = data[STATUS_W +: USER_W];
            got_tid    = data[STATUS_W+USER_W +: TASK_W];
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected result item, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            if (got_status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got_status);
                errors++;
            end
            if (got_owner !== want.owner) begin
                $display("%0t: owner mismatch, expected %h, actual %h",
                         $time, want.owner, got_owner);
                errors++;
            end
            if (got_tid !== want.tid) begin
                $display("%0t: task id mismatch, expected %h, actual %h",
                         $time, want.tid, got_tid);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    task_table_model model = new();
    int              burst_left = 0;
    int              ready_left = 0;
    bit              ready_now  = 1'b0;

    indexed_task_priority_table_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // receiver stall pattern: runs of ready and stall, now and then a long ready stretch
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    ready_now  = 1'b1;
                    ready_left = $urandom_range(1, 30);
                end
                6, 7, 8: begin
                    ready_now  = 1'b0;
                    ready_left = $urandom_range(1, 40);
                end
                default: begin
                    ready_now  = 1'b1;
                    ready_left = 300;
                end
            endcase
        end
        ready_left--;
        m_axis_tready <= ready_now;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            model.compare_reply(m_axis_tdata);
        end
    end

    task automatic send_request(t_kind kind, logic [USER_W-1:0] user,
                                logic [TASK_W-1:0] id, logic [PRIO_W-1:0] prio);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, prio, id, user};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        model.apply_request(kind, user, id, prio);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 80)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    function automatic logic [PRIO_W-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return PRIO_W'($urandom_range(0, 7));
        end else if (r == 4) begin
            return ($urandom_range(0, 1) == 0) ? '0 : '1;
        end
        return PRIO_W'($urandom_range(0, 30'h3FFFFFFF));
    endfunction

    function automatic logic [TASK_W-1:0] pick_id(int live_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < live_pct && model.live_count() > 0) begin
            return model.random_live_id();
        end else if (r < live_pct + 25) begin
            return ($urandom_range(0, 1) == 0) ? TASK_W'($urandom_range(0, 47))
                                               : TASK_W'(20'hFFFFF - $urandom_range(0, 47));
        end
        return TASK_W'($urandom_range(0, 20'hFFFFF));
    endfunction

    initial begin
        int                r;
        bit                filling;
        t_kind             kind;
        logic [USER_W-1:0] user;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, absent ids
        send_request(KIND_POP, 20'hFFFFF, 20'hFFFFF, '1);
        send_request(KIND_EDIT, 20'h12345, 20'h00000, 30'h1);
        send_request(KIND_REMOVE, 20'h0, 20'hFFFFF, '0);
        // field extremes and a duplicate add
        send_request(KIND_ADD, 20'h00000, 20'h00000, 30'h0);
        send_request(KIND_ADD, 20'hFFFFF, 20'hFFFFF, 30'h3FFFFFFF);
        send_request(KIND_ADD, 20'h00005, 20'h00000, 30'h7);
        send_request(KIND_ADD, 20'hABCDE, 20'h12345, 30'h3FFFFFFF);
        send_request(KIND_ADD, 20'h54321, 20'h00055, 30'h100);
        send_request(KIND_EDIT, 20'hFFFFF, 20'h00000, 30'h3FFFFFFF);
        // ties on priority go to the higher task id
        send_request(KIND_POP, 20'h0, 20'h0, '0);
        send_request(KIND_POP, 20'h0, 20'h0, '0);
        send_request(KIND_POP, 20'hFFFFF, 20'h00055, '1);
        send_request(KIND_REMOVE, 20'h0, 20'h00055, '0);
        send_request(KIND_REMOVE, 20'h0, 20'h00055, '0);
        send_request(KIND_EDIT, 20'h0, 20'h00055, 30'h2AAAAAAA);
        send_request(KIND_POP, 20'h0, 20'h0, '0);
        send_request(KIND_ADD, 20'h55555, 20'hAAAAA, 30'h15555555);
        send_request(KIND_ADD, 20'hAAAAA, 20'h55555, 30'h2AAAAAAA);
        send_request(KIND_POP, 20'h0, 20'h0, '0);
        send_request(KIND_POP, 20'h0, 20'h0, '0);

        // alternate fill and drain phases so the table runs full and empty
        filling = 1'b1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 120 == 0) begin
                filling = (i % 240 == 0);
            end
            r    = $urandom_range(0, 99);
            user = USER_W'($urandom_range(0, 20'hFFFFF));
            if (r < (filling ? 60 : 15)) begin
                kind = KIND_ADD;
            end else if (r < (filling ? 75 : 30)) begin
                kind = KIND_EDIT;
            end else if (r < (filling ? 85 : 55)) begin
                kind = KIND_REMOVE;
            end else begin
                kind = KIND_POP;
            end
            send_request(kind, user, pick_id((kind == KIND_ADD) ? 15 : 70), pick_prio());
        end
        s_axis_tvalid <= 1'b0;

        while (model.expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (model.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("FAILURE");
        $finish;
    end

endmodule
